// ----- rtl/tlcc_pkg.sv -----
`default_nettype none

package tlcc_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned MS_PER_DIGIT = 1000;
  localparam int unsigned MAX_DIGIT    = 9;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_GREEN_TIME  = 3'd0,
    REG_YELLOW_TIME = 3'd1,
    REG_RED_TIME    = 3'd2,
    REG_THRESHOLD   = 3'd3,
    REG_HOLDOFF     = 3'd4
  } reg_idx_t;

  localparam logic [TIME_W-1:0]  GREEN_RST     = 16'd5000;
  localparam logic [TIME_W-1:0]  YELLOW_RST    = 16'd2000;
  localparam logic [TIME_W-1:0]  RED_RST       = 16'd5000;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd200;
  localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 10'd500;

  // seconds digit: clamp(ms / 1000, 0, 9), done as nine parallel compares
  function automatic logic [DIGIT_W-1:0] ms_to_digit(input logic [TIME_W-1:0] ms);
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int k = 1; k <= MAX_DIGIT; k++) begin
      if (ms >= TIME_W'(k * MS_PER_DIGIT)) d = DIGIT_W'(k);
    end
    return d;
  endfunction

  // bit0 = a .. bit6 = g
  function automatic logic [SEG_W-1:0] digit_to_seg(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/traffic_light_countdown_controller_unit.sv -----
`default_nettype none

// Traffic light countdown controller.
// Input channel (in_valid/in_stall): one transfer per timer tick of TICK_MS ms,
// carrying a light sensor sample and a buzzer request.
// Output channel (out_valid/out_stall): exactly one result per tick: lamp
// drives, seven-segment pattern of the seconds left, buzzer drive, car flag
// and the saturating car total.
// The result of a tick is in the output register on the clock after its
// transfer. Throughput: one tick per cycle unless out_stall holds it, set
// by the single output register, refilled in the same cycle that it drains.
// When the receiver stalls a full output register, in_stall rises and the
// result holds until it is taken; no tick is lost or reordered.
// Configuration goes through the APB port (registers at 4*index); phase
// lengths apply when that phase is next entered, threshold and holdoff at once.
// Reset: green phase with 5000 ms loaded, holdoff and car count cleared,
// registers at their defaults, output register empty. No clearing pass.
module traffic_light_countdown_controller_unit #(
  parameter int unsigned TICK_MS = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tlcc_pkg::LEVEL_W-1:0]    in_light_level,
  input  wire logic                            in_buzzer_request,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_lamp_green,
  output logic                                 out_lamp_yellow,
  output logic                                 out_lamp_red,
  output logic [tlcc_pkg::SEG_W-1:0]           out_segment_pattern,
  output logic                                 out_buzzer_drive,
  output logic                                 out_car_seen,
  output logic [tlcc_pkg::COUNT_W-1:0]         out_car_total,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tlcc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tlcc_pkg::DATA_W-1:0]     pwdata,
  output logic [tlcc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  import tlcc_pkg::*;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_t;

  localparam logic [TIME_W-1:0] TICK_T = TIME_W'(TICK_MS);
  localparam logic [HOLD_W-1:0] TICK_H = HOLD_W'(TICK_MS);

  // configuration
  logic [TIME_W-1:0]  green_time_r, yellow_time_r, red_time_r;
  logic [LEVEL_W-1:0] threshold_r;
  logic [HOLD_W-1:0]  holdoff_cfg_r;

  // tick state
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  remaining_r, remaining_nxt;
  logic [HOLD_W-1:0]  holdoff_r, holdoff_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // output register
  logic               out_valid_r;
  logic               lamp_g_r, lamp_y_r, lamp_r_r;
  logic [SEG_W-1:0]   seg_r;
  logic               buzz_r, seen_r;
  logic [COUNT_W-1:0] total_r;

  logic               accept;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [HOLD_W-1:0]  holdoff_dec;
  logic               seen_nxt;
  logic               buzz_nxt;
  logic [SEG_W-1:0]   seg_nxt;

  assign pready   = 1'b1;
  assign cfg_idx  = reg_idx_t'(paddr[4:2]);
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_GREEN_TIME:  prdata = DATA_W'(green_time_r);
      REG_YELLOW_TIME: prdata = DATA_W'(yellow_time_r);
      REG_RED_TIME:    prdata = DATA_W'(red_time_r);
      REG_THRESHOLD:   prdata = DATA_W'(threshold_r);
      REG_HOLDOFF:     prdata = DATA_W'(holdoff_cfg_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    seg_nxt     = digit_to_seg(ms_to_digit(remaining_r));
    buzz_nxt    = 1'b0;
    seen_nxt    = 1'b0;
    holdoff_nxt = holdoff_r;
    count_nxt   = count_r;
    holdoff_dec = (holdoff_r > TICK_H) ? holdoff_r - TICK_H : '0;

    if (phase_r == PH_RED) begin
      buzz_nxt    = in_buzzer_request;
      holdoff_nxt = holdoff_dec;
      if (holdoff_dec == '0 && in_light_level < threshold_r) begin
        seen_nxt    = 1'b1;
        holdoff_nxt = holdoff_cfg_r;
        if (count_r != '1) count_nxt = count_r + 1'b1;
      end
    end

    phase_nxt     = phase_r;
    remaining_nxt = remaining_r - TICK_T;
    if (remaining_r <= TICK_T) begin
      unique case (phase_r)
        PH_RED: begin
          phase_nxt     = PH_GREEN;
          remaining_nxt = green_time_r;
          holdoff_nxt   = '0;
        end
        PH_YELLOW: begin
          phase_nxt     = PH_RED;
          remaining_nxt = red_time_r;
        end
        default: begin
          phase_nxt     = PH_YELLOW;
          remaining_nxt = yellow_time_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_time_r  <= GREEN_RST;
      yellow_time_r <= YELLOW_RST;
      red_time_r    <= RED_RST;
      threshold_r   <= THRESHOLD_RST;
      holdoff_cfg_r <= HOLDOFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GREEN_TIME:  green_time_r  <= pwdata[TIME_W-1:0];
        REG_YELLOW_TIME: yellow_time_r <= pwdata[TIME_W-1:0];
        REG_RED_TIME:    red_time_r    <= pwdata[TIME_W-1:0];
        REG_THRESHOLD:   threshold_r   <= pwdata[LEVEL_W-1:0];
        REG_HOLDOFF:     holdoff_cfg_r <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // tick state and the result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_GREEN;
      remaining_r <= GREEN_RST;
      holdoff_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        remaining_r <= remaining_nxt;
        holdoff_r   <= holdoff_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        lamp_g_r    <= (phase_r == PH_GREEN);
        lamp_y_r    <= (phase_r == PH_YELLOW);
        lamp_r_r    <= (phase_r == PH_RED);
        seg_r       <= seg_nxt;
        buzz_r      <= buzz_nxt;
        seen_r      <= seen_nxt;
        total_r     <= count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lamp_green      = lamp_g_r;
  assign out_lamp_yellow     = lamp_y_r;
  assign out_lamp_red        = lamp_r_r;
  assign out_segment_pattern = seg_r;
  assign out_buzzer_drive    = buzz_r;
  assign out_car_seen        = seen_r;
  assign out_car_total       = total_r;

endmodule

`default_nettype wire

// ----- tb/traffic_light_countdown_controller_unit_checker.sv -----
`timescale 1ns / 100ps

module traffic_light_countdown_controller_unit_checker #(
  parameter int unsigned TICK_MS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [tlcc_pkg::LEVEL_W-1:0] in_light_level,
  input  logic                         in_buzzer_request,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_lamp_green,
  input  logic                         out_lamp_yellow,
  input  logic                         out_lamp_red,
  input  logic [tlcc_pkg::SEG_W-1:0]   out_segment_pattern,
  input  logic                         out_buzzer_drive,
  input  logic                         out_car_seen,
  input  logic [tlcc_pkg::COUNT_W-1:0] out_car_total,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tlcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlcc_pkg::DATA_W-1:0]  pwdata,
  output int                           fail_count,
  output int                           pending
);

  import tlcc_pkg::*;

  typedef enum logic [1:0] {
    LIGHT_GREEN,
    LIGHT_YELLOW,
    LIGHT_RED
  } light_t;

  typedef struct packed {
    logic               green;
    logic               yellow;
    logic               red;
    logic [SEG_W-1:0]   segments;
    logic               buzzer;
    logic               car_seen;
    logic [COUNT_W-1:0] car_total;
  } tick_result_t;

  // digits 9 down to 0, so that element k is the pattern of digit k
  localparam logic [9:0][SEG_W-1:0] SEGMENT_ROM = {
    7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  logic [TIME_W-1:0]  green_cfg;
  logic [TIME_W-1:0]  yellow_cfg;
  logic [TIME_W-1:0]  red_cfg;
  logic [LEVEL_W-1:0] threshold_cfg;
  logic [HOLD_W-1:0]  holdoff_cfg;

  light_t             lamp_phase;
  logic [16:0]        remaining_ms;
  logic [HOLD_W-1:0]  holdoff_left;
  logic [COUNT_W-1:0] car_count;

  tick_result_t expected_ticks[$];
  int           results_seen;

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  task automatic report_error(input string msg);
    if (fail_count < 100) $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, field, got, want));
  endtask

  function automatic tick_result_t advance_tick(input logic [LEVEL_W-1:0] level,
                                                input logic req);
    tick_result_t r;
    int unsigned  digit;
    r = '0;
    digit = remaining_ms / MS_PER_DIGIT;
    if (digit > MAX_DIGIT) digit = MAX_DIGIT;
    r.segments = SEGMENT_ROM[digit];
    if (lamp_phase == LIGHT_RED) begin
      r.buzzer = req;
      holdoff_left = (holdoff_left > TICK_MS) ? HOLD_W'(holdoff_left - TICK_MS) : '0;
      if (holdoff_left == '0 && level < threshold_cfg) begin
        r.car_seen = 1'b1;
        if (car_count != '1) car_count++;
        holdoff_left = holdoff_cfg;
      end
    end
    r.green = (lamp_phase == LIGHT_GREEN);
    r.yellow = (lamp_phase == LIGHT_YELLOW);
    r.red = (lamp_phase == LIGHT_RED);
    r.car_total = car_count;
    // phase times are picked up only on entry
    if (remaining_ms <= TICK_MS) begin
      case (lamp_phase)
        LIGHT_RED: begin
          holdoff_left = '0;
          lamp_phase = LIGHT_GREEN;
          remaining_ms = 17'(green_cfg);
        end
        LIGHT_YELLOW: begin
          lamp_phase = LIGHT_RED;
          remaining_ms = 17'(red_cfg);
        end
        default: begin
          lamp_phase = LIGHT_YELLOW;
          remaining_ms = 17'(yellow_cfg);
        end
      endcase
    end else begin
      remaining_ms = remaining_ms - 17'(TICK_MS);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      green_cfg = GREEN_RST;
      yellow_cfg = YELLOW_RST;
      red_cfg = RED_RST;
      threshold_cfg = THRESHOLD_RST;
      holdoff_cfg = HOLDOFF_RST;
      lamp_phase = LIGHT_GREEN;
      remaining_ms = 17'(GREEN_RST);
      holdoff_left = '0;
      car_count = '0;
      expected_ticks.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          report_error($sformatf("result %0d arrived with no tick outstanding",
                                 results_seen));
        end else begin
          want = expected_ticks.pop_front();
          check_field("lamp_green", out_lamp_green, want.green);
          check_field("lamp_yellow", out_lamp_yellow, want.yellow);
          check_field("lamp_red", out_lamp_red, want.red);
          check_field("segment_pattern", out_segment_pattern, want.segments);
          check_field("buzzer_drive", out_buzzer_drive, want.buzzer);
          check_field("car_seen", out_car_seen, want.car_seen);
          check_field("car_total", out_car_total, want.car_total);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_GREEN_TIME:  green_cfg = pwdata[TIME_W-1:0];
          REG_YELLOW_TIME: yellow_cfg = pwdata[TIME_W-1:0];
          REG_RED_TIME:    red_cfg = pwdata[TIME_W-1:0];
          REG_THRESHOLD:   threshold_cfg = pwdata[LEVEL_W-1:0];
          REG_HOLDOFF:     holdoff_cfg = pwdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(advance_tick(in_light_level, in_buzzer_request));
      pending <= expected_ticks.size();
    end
  end

endmodule

// ----- tb/traffic_light_countdown_controller_unit_tb.sv -----
`timescale 1ns / 100ps

module traffic_light_countdown_controller_unit_tb;
  import tlcc_pkg::*;

  localparam int unsigned TICK_MS      = 20;
  localparam int unsigned CYCLE_LIMIT  = 20_000;
  localparam int unsigned CHOKE_AT     = 200;
  localparam int unsigned CHOKE_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid;
  logic               in_stall;
  logic [LEVEL_W-1:0] in_light_level;
  logic               in_buzzer_request;
  logic               out_valid;
  logic               out_stall;
  logic               out_lamp_green;
  logic               out_lamp_yellow;
  logic               out_lamp_red;
  logic [SEG_W-1:0]   out_segment_pattern;
  logic               out_buzzer_drive;
  logic               out_car_seen;
  logic [COUNT_W-1:0] out_car_total;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int fail_count;
  int pending;

  bit                 sender_quiet = 1'b0;
  bit                 choke_done = 1'b0;
  int unsigned        results_taken = 0;
  int unsigned        cycle_count = 0;
  logic [LEVEL_W-1:0] cur_threshold = THRESHOLD_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  traffic_light_countdown_controller_unit #(.TICK_MS(TICK_MS)) dut (.*);

  traffic_light_countdown_controller_unit_checker #(.TICK_MS(TICK_MS)) checker_i (
    .fail_count(fail_count),
    .pending(pending),
    .*
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("traffic_light_countdown_controller_unit verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, and a window with no stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) results_taken++;
      if (!choke_done && results_taken == CHOKE_AT) begin
        choke_done = 1'b1;
        out_stall <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else if (results_taken >= 300 && results_taken < 400) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 12);
      end
    end
  end

  task automatic offer_tick(input logic [LEVEL_W-1:0] level, input logic req);
    if (!sender_quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_light_level <= level;
    in_buzzer_request <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_lights(input logic [TIME_W-1:0] green_ms,
                                input logic [TIME_W-1:0] yellow_ms,
                                input logic [TIME_W-1:0] red_ms,
                                input logic [LEVEL_W-1:0] threshold,
                                input logic [HOLD_W-1:0] holdoff);
    write_reg(REG_GREEN_TIME, DATA_W'(green_ms));
    write_reg(REG_YELLOW_TIME, DATA_W'(yellow_ms));
    write_reg(REG_RED_TIME, DATA_W'(red_ms));
    write_reg(REG_THRESHOLD, DATA_W'(threshold));
    write_reg(REG_HOLDOFF, DATA_W'(holdoff));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_threshold = threshold;
  endtask

  // extremes, near-threshold samples and plain random ones
  function automatic logic [LEVEL_W-1:0] pick_level();
    int unsigned roll;
    int          lvl;
    roll = $urandom_range(0, 7);
    case (roll)
      0: lvl = 0;
      1: lvl = 4095;
      2, 3: lvl = int'(cur_threshold) + int'($urandom_range(0, 16)) - 8;
      default: lvl = $urandom_range(0, 4095);
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 4095) lvl = 4095;
    return LEVEL_W'(lvl);
  endfunction

  // mostly short phases so the lights cycle often
  function automatic logic [TIME_W-1:0] pick_phase_ms();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    case (roll)
      0: return 16'd1;
      1: return 16'd20;
      2: return 16'd21;
      default: return TIME_W'($urandom_range(1, 2500));
    endcase
  endfunction

  initial begin
    in_valid = 1'b0;
    in_light_level = '0;
    in_buzzer_request = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: green with 5 s on the display
    offer_tick(12'd0, 1'b1);
    offer_tick(12'd4095, 1'b0);
    offer_tick(12'd2048, 1'b1);
    wait_drained();

    // zero-length green, 1 ms yellow, short red that counts a car on levels below 4095
    program_lights(16'd0, 16'd1, 16'd300, 12'd4095, 10'd0);
    for (int i = 0; i < 19; i++) begin
      case (i % 3)
        0: offer_tick(12'd0, i[0]);
        1: offer_tick(12'd4095, i[0]);
        default: offer_tick(12'd4094, i[0]);
      endcase
    end
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_lights(16'd20, 16'd21, 16'd65535, 12'd4095, 10'd1023);
        1: program_lights(pick_phase_ms(), pick_phase_ms(), pick_phase_ms(), 12'd0, 10'd0);
        default: program_lights(pick_phase_ms(), pick_phase_ms(), pick_phase_ms(),
                                LEVEL_W'($urandom_range(0, 4095)),
                                HOLD_W'($urandom_range(0, 1023)));
      endcase
      sender_quiet = (p == 3);
      for (int i = 0; i < 65; i++) offer_tick(pick_level(), 1'($urandom_range(0, 1)));
      wait_drained();
    end
    sender_quiet = 1'b0;

    program_lights(16'd65535, 16'd65535, 16'd65535, 12'd0, 10'd1023);
    for (int i = 0; i < 20; i++) offer_tick(pick_level(), 1'($urandom_range(0, 1)));
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("traffic_light_countdown_controller_unit verification clean");
    else
      $display("traffic_light_countdown_controller_unit verification failed");
    $finish;
  end

endmodule
